[rtl/itp_pkg.sv]
package itp_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CONSUMED_WIDTH  = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [5:0] LETTER_OFFSET = 6'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // one classified character as it travels from front to back
  typedef struct packed {
    logic       first;
    logic [5:0] base_sel;
    logic       signed_mode;
    logic       is_alnum;
    logic [5:0] digit;
    logic       is_blank;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
  } item_t;

endpackage

[rtl/itp_ifs.sv]
interface itp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic [5:0] base_sel;
  logic       signed_mode;

  modport source (output valid, ch, first, base_sel, signed_mode, input ready);
  modport sink (input valid, ch, first, base_sel, signed_mode, output ready);
endinterface

interface itp_result_if #(
  parameter int VALUE_WIDTH = itp_pkg::VALUE_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic [VALUE_WIDTH-1:0]              value;
  logic [itp_pkg::CONSUMED_WIDTH-1:0]  consumed;
  logic                                any_digits;

  modport source (output valid, value, consumed, any_digits, input ready);
  modport sink (input valid, value, consumed, any_digits, output ready);
endinterface

[rtl/itp_front.sv]
module itp_front (
  itp_char_if.sink          chars,
  input  logic              queue_full,
  output logic              push,
  output itp_pkg::item_t    item
);

  always_comb begin
    chars.ready = !queue_full;
    push        = chars.valid && !queue_full;
  end

  // character classification
  always_comb begin
    item             = '0;
    item.first       = chars.first;
    item.base_sel    = chars.base_sel;
    item.signed_mode = chars.signed_mode;
    item.is_blank    = (chars.ch == itp_pkg::CH_SPACE) ||
                       (chars.ch >= itp_pkg::CH_TAB && chars.ch <= itp_pkg::CH_CR);
    item.is_plus     = (chars.ch == itp_pkg::CH_PLUS);
    item.is_minus    = (chars.ch == itp_pkg::CH_MINUS);
    item.is_zero     = (chars.ch == itp_pkg::CH_ZERO);
    item.is_x        = (chars.ch == itp_pkg::CH_LO_X) || (chars.ch == itp_pkg::CH_UP_X);
    if (chars.ch >= itp_pkg::CH_ZERO && chars.ch <= itp_pkg::CH_NINE) begin
      item.is_alnum = 1'b1;
      item.digit    = 6'(chars.ch - itp_pkg::CH_ZERO);
    end else if (chars.ch >= itp_pkg::CH_LO_A && chars.ch <= itp_pkg::CH_LO_Z) begin
      item.is_alnum = 1'b1;
      item.digit    = 6'(chars.ch - itp_pkg::CH_LO_A) + itp_pkg::LETTER_OFFSET;
    end else if (chars.ch >= itp_pkg::CH_UP_A && chars.ch <= itp_pkg::CH_UP_Z) begin
      item.is_alnum = 1'b1;
      item.digit    = 6'(chars.ch - itp_pkg::CH_UP_A) + itp_pkg::LETTER_OFFSET;
    end
  end

endmodule

[rtl/itp_queue.sv]
module itp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itp_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output itp_pkg::item_t rd_item,
  output logic           not_empty
);

  localparam int DEPTH = itp_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  itp_pkg::item_t store [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/itp_back.sv]
module itp_back #(
  parameter int VALUE_WIDTH = itp_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = itp_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  itp_pkg::item_t item,
  output logic           pop,
  itp_result_if.source   result
);

  localparam int SW = (COUNT_WIDTH > itp_pkg::CONSUMED_WIDTH) ?
                      COUNT_WIDTH : itp_pkg::CONSUMED_WIDTH;

  itp_pkg::phase_t          phase;
  logic [VALUE_WIDTH-1:0]   acc;
  logic [COUNT_WIDTH-1:0]   cnt;
  logic                     neg;
  logic [5:0]               base;
  logic                     msigned;
  logic                     seen;

  logic                                res_valid;
  logic [VALUE_WIDTH-1:0]              res_value;
  logic [itp_pkg::CONSUMED_WIDTH-1:0]  res_consumed;
  logic                                res_any;

  // state as seen by this character (first restarts everything)
  itp_pkg::phase_t          e_phase;
  logic [VALUE_WIDTH-1:0]   e_acc;
  logic [COUNT_WIDTH-1:0]   e_cnt;
  logic                     e_neg;
  logic [5:0]               e_base;
  logic                     e_signed;
  logic                     e_seen;

  itp_pkg::phase_t          phase_next;
  logic [VALUE_WIDTH-1:0]   acc_next;
  logic [COUNT_WIDTH-1:0]   cnt_next;
  logic                     neg_next;
  logic [5:0]               base_next;
  logic                     seen_next;

  logic                     start;
  logic                     go_digit;
  logic                     take;
  logic                     bump;
  logic                     emit;
  logic [5:0]               dig_base;
  logic                     dig_seen;
  logic                     is_auto;
  logic [SW-1:0]            cnt_wide;

  logic [VALUE_WIDTH-1:0]              emit_value;
  logic [itp_pkg::CONSUMED_WIDTH-1:0]  emit_consumed;

  assign pop = item_valid && (!res_valid || result.ready);

  always_comb begin
    e_phase  = item.first ? itp_pkg::PH_LEAD : phase;
    e_acc    = item.first ? '0 : acc;
    e_cnt    = item.first ? '0 : cnt;
    e_neg    = item.first ? 1'b0 : neg;
    e_base   = item.first ? item.base_sel : base;
    e_signed = item.first ? item.signed_mode : msigned;
    e_seen   = item.first ? 1'b0 : seen;
    is_auto  = (e_base == itp_pkg::BASE_AUTO);
  end

  // next state and step decision
  always_comb begin
    phase_next = e_phase;
    neg_next   = e_neg;
    base_next  = e_base;
    seen_next  = e_seen;
    start      = 1'b0;
    go_digit   = 1'b0;
    take       = 1'b0;
    bump       = 1'b0;
    emit       = 1'b0;
    dig_base   = e_base;
    dig_seen   = e_seen;
    case (e_phase)
      itp_pkg::PH_LEAD: begin
        if (item.is_blank) begin
          bump = 1'b1;
        end else if (item.is_plus) begin
          bump       = 1'b1;
          phase_next = itp_pkg::PH_SIGNED;
        end else if (item.is_minus && e_signed) begin
          bump       = 1'b1;
          neg_next   = 1'b1;
          phase_next = itp_pkg::PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      itp_pkg::PH_SIGNED: start = 1'b1;
      itp_pkg::PH_ZERO: begin
        if (item.is_x) begin
          bump       = 1'b1;
          base_next  = itp_pkg::BASE_HEX;
          phase_next = itp_pkg::PH_DIGITS;
        end else begin
          go_digit = 1'b1;
          dig_base = is_auto ? itp_pkg::BASE_OCT : e_base;
          dig_seen = is_auto ? !e_signed : 1'b1;
        end
      end
      itp_pkg::PH_DIGITS: go_digit = 1'b1;
      default: ;
    endcase
    if (start) begin
      if ((is_auto || e_base == itp_pkg::BASE_HEX) && item.is_zero) begin
        bump       = 1'b1;
        phase_next = itp_pkg::PH_ZERO;
      end else begin
        go_digit = 1'b1;
        dig_base = is_auto ? itp_pkg::BASE_DEC : e_base;
      end
    end
    if (go_digit) begin
      base_next = dig_base;
      if (item.is_alnum && item.digit < dig_base) begin
        take       = 1'b1;
        bump       = 1'b1;
        seen_next  = 1'b1;
        phase_next = itp_pkg::PH_DIGITS;
      end else begin
        emit       = 1'b1;
        seen_next  = dig_seen;
        phase_next = itp_pkg::PH_IDLE;
      end
    end
  end

  // datapath next values
  always_comb begin
    acc_next = take ? (e_acc * VALUE_WIDTH'(dig_base)) + VALUE_WIDTH'(item.digit) : e_acc;
    cnt_next = (bump && e_cnt != '1) ? e_cnt + 1'b1 : e_cnt;
  end

  // result of a terminating character
  always_comb begin
    cnt_wide      = SW'(e_cnt);
    emit_value    = '0;
    emit_consumed = '0;
    if (dig_seen) begin
      emit_value    = e_neg ? ('0 - e_acc) : e_acc;
      emit_consumed = (cnt_wide > SW'({itp_pkg::CONSUMED_WIDTH{1'b1}})) ?
                      '1 : cnt_wide[itp_pkg::CONSUMED_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= itp_pkg::PH_IDLE;
      acc     <= '0;
      cnt     <= '0;
      neg     <= 1'b0;
      base    <= '0;
      msigned <= 1'b0;
      seen    <= 1'b0;
    end else if (pop) begin
      phase   <= phase_next;
      acc     <= acc_next;
      cnt     <= cnt_next;
      neg     <= neg_next;
      base    <= base_next;
      msigned <= e_signed;
      seen    <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_value    <= emit_value;
      res_consumed <= emit_consumed;
      res_any      <= dig_seen;
    end
  end

  assign result.valid      = res_valid;
  assign result.value      = res_value;
  assign result.consumed   = res_consumed;
  assign result.any_digits = res_any;

  a_zero_base: assert property (@(posedge clk) disable iff (rst)
    phase == itp_pkg::PH_ZERO |-> (base == itp_pkg::BASE_AUTO || base == itp_pkg::BASE_HEX))
    else $error("prefix phase with a base other than auto or hex");

  a_digits_base: assert property (@(posedge clk) disable iff (rst)
    phase == itp_pkg::PH_DIGITS |-> base != itp_pkg::BASE_AUTO)
    else $error("digit phase with unresolved base");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_any |-> (res_value == '0 && res_consumed == '0))
    else $error("result without digits carries data");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_any |-> res_consumed != '0)
    else $error("result with digits reports zero consumed");

endmodule

[rtl/integer_text_parser.sv]
// a character accepted into the queue is parsed from there by the back end; its
//   result, if it ends the number, is registered in the result register
// throughput: one character per cycle while the queue has room and the result is
//   not stalled, with the multiply-add (accumulator times six-bit base plus digit) in the back end
// reset (synchronous, active high): queue empty, parser idle, no result pending
module integer_text_parser #(
  parameter int VALUE_WIDTH = itp_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = itp_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  itp_char_if.sink     chars,
  itp_result_if.source result
);

  // classified character entering the queue
  itp_pkg::item_t wr_item;
  // oldest queued character, presented to the parser
  itp_pkg::item_t rd_item;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_not_empty;

  // front end: takes a transaction whenever the queue has room and sorts the
  // byte into white space, sign, zero, x and digit value
  itp_front u_front (
    .chars      (chars),
    .queue_full (queue_full),
    .push       (push),
    .item       (wr_item)
  );

  // short queue so a stalled result does not immediately stall the input
  itp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (wr_item),
    .full      (queue_full),
    .pop       (pop),
    .rd_item   (rd_item),
    .not_empty (queue_not_empty)
  );

  // back end: parse state machine, accumulator and the registered result;
  // it consumes a character whenever the result register is free or draining
  itp_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_not_empty),
    .item       (rd_item),
    .pop        (pop),
    .result     (result)
  );

endmodule

[bench/integer_text_parser_tb.sv]
module integer_text_parser_tb;
  import itp_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int COUNT_W     = COUNT_WIDTH_DEF;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_REPORTS = 100;
  localparam int RANDOM_CHARS = 240;
  localparam int LONG_RUN    = 20;
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_W) - 1);

  // one character transaction as the sender presents it
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic [5:0] base_sel;
    logic       signed_mode;
  } char_item_t;

  // one parsed number as the block reports it
  typedef struct packed {
    logic [VW-1:0]             value;
    logic [CONSUMED_WIDTH-1:0] consumed;
    logic                      any_digits;
  } number_t;

  logic clk;
  logic rst;

  itp_char_if chars_bus();
  itp_result_if #(.VALUE_WIDTH(VW)) result_bus();

  integer_text_parser #(
    .VALUE_WIDTH(VW),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_bus),
    .result(result_bus)
  );

  char_item_t pending_chars[$];
  number_t    expected_numbers[$];

  int total_chars;
  int chars_accepted;
  int strings_started;
  int numbers_checked;
  int numbers_with_digits;
  int errors;

  // parser model state, mirrors the block after each accepted character
  phase_t        m_phase  = PH_IDLE;
  logic [VW-1:0] m_acc    = '0;
  logic [31:0]   m_count  = '0;
  logic          m_neg    = 1'b0;
  logic [5:0]    m_base   = '0;
  logic          m_signed = 1'b0;
  logic          m_seen   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------

  // digit value of a character, 255 when it is no alphanumeric
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'(LETTER_OFFSET);
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 8'(LETTER_OFFSET);
    return 8'hFF;
  endfunction

  // character counter saturates at the top of its width
  task automatic bump_count();
    if (m_count < COUNT_MAX) m_count++;
  endtask

  // inside the digits: accumulate, or close the number and queue its result
  task automatic take_digit(input logic [7:0] c);
    logic [7:0] d;
    number_t    n;
    d = digit_value(c);
    if (d < {2'b00, m_base}) begin
      m_acc = m_acc * VW'(m_base) + VW'(d);
      bump_count();
      m_seen = 1'b1;
    end else begin
      n.any_digits = m_seen;
      n.value      = !m_seen ? '0 : (m_neg ? -m_acc : m_acc);
      n.consumed   = !m_seen ? '0 :
                     (m_count > 32'hFFFF ? 16'hFFFF : m_count[CONSUMED_WIDTH-1:0]);
      expected_numbers.push_back(n);
      m_phase = PH_IDLE;
    end
  endtask

  // first character of the number proper: a zero may open a prefix
  task automatic start_number(input logic [7:0] c);
    if ((m_base == BASE_AUTO || m_base == BASE_HEX) && c == CH_ZERO) begin
      bump_count();
      m_phase = PH_ZERO;
    end else begin
      if (m_base == BASE_AUTO) m_base = BASE_DEC;
      m_phase = PH_DIGITS;
      take_digit(c);
    end
  endtask

  task automatic predict_char(input logic [7:0] c, input logic f, input logic [5:0] b,
                              input logic s);
    if (f) begin
      // a new string drops whatever parse was running
      m_acc    = '0;
      m_count  = '0;
      m_neg    = 1'b0;
      m_seen   = 1'b0;
      m_base   = b;
      m_signed = s;
      m_phase  = PH_LEAD;
    end
    case (m_phase)
      PH_LEAD: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          bump_count();
        end else if (c == CH_PLUS) begin
          bump_count();
          m_phase = PH_SIGNED;
        end else if (c == CH_MINUS && m_signed) begin
          m_neg = 1'b1;
          bump_count();
          m_phase = PH_SIGNED;
        end else begin
          start_number(c);
        end
      end
      PH_SIGNED: start_number(c);
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          bump_count();
          m_base  = BASE_HEX;
          m_phase = PH_DIGITS;
        end else begin
          // bare leading zero: octal mark in auto base, a digit only when unsigned
          if (m_base == BASE_AUTO) begin
            m_base = BASE_OCT;
            m_seen = !m_signed;
          end else begin
            m_seen = 1'b1;
          end
          m_phase = PH_DIGITS;
          take_digit(c);
        end
      end
      PH_DIGITS: take_digit(c);
      default: ;  // idle: stray bytes are ignored
    endcase
  endtask

  // ---------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------

  // base and mode only matter with first, so they are scrambled otherwise
  task automatic push_char(input logic [7:0] c, input logic f, input logic [5:0] b,
                           input logic s);
    char_item_t it;
    it.ch          = c;
    it.first       = f;
    it.base_sel    = f ? b : 6'($urandom_range(0, 63));
    it.signed_mode = f ? s : 1'($urandom_range(0, 1));
    pending_chars.push_back(it);
  endtask

  // a whole string; a negative terminator leaves the string open
  task automatic queue_text(input string s, input int term, input logic [5:0] b,
                            input logic sgn);
    bit lead;
    lead = 1'b1;
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], lead, b, sgn);
      lead = 1'b0;
    end
    if (term >= 0) push_char(8'(term), lead, b, sgn);
  endtask

  // well-formed number with random spacing, sign, prefix and digits
  task automatic queue_random_number(input bit terminate);
    logic [5:0] b;
    logic       sgn;
    logic [7:0] c;
    bit         lead;
    int         radix;
    int         nd;
    int         d;
    int         r;
    case ($urandom_range(0, 7))
      0, 1:    b = BASE_AUTO;
      2:       b = BASE_OCT;
      3:       b = BASE_DEC;
      4:       b = BASE_HEX;
      5:       b = 6'd2;
      6:       b = 6'd36;
      default: b = 6'($urandom_range(0, 63));
    endcase
    sgn  = 1'($urandom_range(0, 1));
    lead = 1'b1;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 5);
      push_char(r == 5 ? CH_SPACE : CH_TAB + 8'(r), lead, b, sgn);
      lead = 1'b0;
    end
    r = $urandom_range(0, 3);
    if (r < 2) begin
      push_char(r == 0 ? CH_PLUS : CH_MINUS, lead, b, sgn);
      lead = 1'b0;
    end
    radix = (b == BASE_AUTO) ? 10 : int'(b);
    if (b == BASE_AUTO || b == BASE_HEX) begin
      r = $urandom_range(0, 3);
      if (r == 0) begin
        push_char(CH_ZERO, lead, b, sgn);
        push_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0, b, sgn);
        lead  = 1'b0;
        radix = 16;
      end else if (r == 1 && b == BASE_AUTO) begin
        push_char(CH_ZERO, lead, b, sgn);
        lead  = 1'b0;
        radix = 8;
      end
    end
    // mostly short numbers, now and then long enough to wrap
    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 8);
    for (int i = 0; i < nd; i++) begin
      d = (radix <= 1) ? 0 : $urandom_range(0, (radix > 36 ? 36 : radix) - 1);
      // keep auto decimal from turning octal on a leading zero
      if (b == BASE_AUTO && radix == 10 && i == 0 && d == 0) d = 1;
      if (d < 10) c = CH_ZERO + 8'(d);
      else c = ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
      push_char(c, lead, b, sgn);
      lead = 1'b0;
    end
    if (terminate) begin
      case ($urandom_range(0, 9))
        0:       c = 8'h00;
        1:       c = CH_ZERO - 8'd1;
        2:       c = CH_NINE + 8'd1;
        3:       c = CH_UP_A - 8'd1;
        4:       c = CH_UP_Z + 8'd1;
        5:       c = CH_LO_A - 8'd1;
        6:       c = CH_LO_Z + 8'd1;
        7:       c = 8'($urandom_range(1, 8));
        default: c = 8'($urandom_range(128, 255));
      endcase
      push_char(c, lead, b, sgn);
    end
  endtask

  initial begin
    int start_size;
    int r;

    rst = 1'b1;
    chars_bus.valid       = 1'b0;
    chars_bus.ch          = '0;
    chars_bus.first       = 1'b0;
    chars_bus.base_sel    = '0;
    chars_bus.signed_mode = 1'b0;
    result_bus.ready      = 1'b0;

    // directed strings
    queue_text("  \t-123", 0, BASE_DEC, 1'b1);
    queue_text("-5", 0, BASE_DEC, 1'b0);            // minus refused when unsigned
    queue_text("+0x1fF", CH_SPACE, BASE_AUTO, 1'b0);
    queue_text("0X", "g", BASE_HEX, 1'b1);          // prefix with no hex digit after it
    queue_text("0", 0, BASE_AUTO, 1'b1);            // lone zero, signed: no number
    queue_text("0", 0, BASE_AUTO, 1'b0);            // lone zero, unsigned: a digit
    queue_text("08", 0, BASE_OCT, 1'b0);
    queue_text("-017", 0, BASE_AUTO, 1'b1);
    queue_text("0755", 0, BASE_HEX, 1'b0);          // zero without x is a plain hex digit
    queue_text("0001", 0, 6'd1, 1'b0);              // base one takes only zeros
    queue_text("zZ", "!", 6'd36, 1'b1);
    queue_text("Zz09", "~", 6'd63, 1'b0);           // oversized base: every letter is a digit
    queue_text("18446744073709551616", 0, BASE_DEC, 1'b0);
    queue_text("-9223372036854775808", 0, BASE_DEC, 1'b1);
    queue_text("FFFFFFFFFFFFFFFFF", 0, BASE_HEX, 1'b1);
    queue_text("\011\012\013\014\015 7", "/", BASE_AUTO, 1'b0);
    queue_text("- 5", 0, BASE_DEC, 1'b1);
    queue_text("++1", 0, BASE_DEC, 1'b0);
    queue_text("99", ":", BASE_DEC, 1'b0);
    // stray bytes while idle
    push_char(8'hFF, 1'b0, BASE_DEC, 1'b0);
    push_char(CH_NINE, 1'b0, BASE_DEC, 1'b0);
    // restart in the middle of a number drops it
    queue_text("12345", -1, BASE_DEC, 1'b0);
    queue_text("42", 0, BASE_AUTO, 1'b1);
    queue_text("1010", "2", 6'd2, 1'b0);
    queue_text("", 0, BASE_DEC, 1'b0);
    // a longer run of blanks as an open string, dropped when the next string starts
    for (int i = 0; i < LONG_RUN; i++) push_char(CH_SPACE, i == 0, BASE_DEC, 1'b0);
    queue_text("12", 0, BASE_DEC, 1'b1);

    // random part: mostly good numbers, some cut short, some noise
    start_size = pending_chars.size();
    while (pending_chars.size() - start_size < RANDOM_CHARS) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        queue_random_number(1'b1);
      end else if (r == 8) begin
        queue_random_number(1'b0);
      end else begin
        repeat ($urandom_range(1, 5))
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end
    end
    queue_random_number(1'b1);
    total_chars = pending_chars.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // drain: every character taken, every number seen, then a short tail
    while (chars_accepted < total_chars) @(posedge clk);
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d characters in %0d strings sent, %0d numbers checked (%0d with digits)",
             chars_accepted, strings_started, numbers_checked, numbers_with_digits);
    $display("%0d mismatches", errors);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // character driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  char_item_t next_char;

  always @(posedge clk) begin
    if (rst) begin
      chars_bus.valid <= 1'b0;
    end else begin
      if (chars_bus.valid && chars_bus.ready) begin
        // the model follows the transaction exactly as it sat on the bus
        predict_char(chars_bus.ch, chars_bus.first, chars_bus.base_sel,
                     chars_bus.signed_mode);
        chars_accepted++;
        if (chars_bus.first) strings_started++;
      end
      // a presented transaction holds until it is taken
      if (!(chars_bus.valid && !chars_bus.ready)) begin
        if (gap_left > 0 || pending_chars.size() == 0) begin
          if (gap_left > 0) gap_left--;
          chars_bus.valid <= 1'b0;
        end else begin
          next_char = pending_chars.pop_front();
          chars_bus.valid       <= 1'b1;
          chars_bus.ch          <= next_char.ch;
          chars_bus.first       <= next_char.first;
          chars_bus.base_sel    <= next_char.base_sel;
          chars_bus.signed_mode <= next_char.signed_mode;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor and receiver stalls
  // ---------------------------------------------------------------------
  int          stall_tick = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    number_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        numbers_checked++;
        if (expected_numbers.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got value %0h consumed %0d",
                     $time, result_bus.value, result_bus.consumed);
        end else begin
          want = expected_numbers.pop_front();
          if (want.any_digits) numbers_with_digits++;
          if (result_bus.value !== want.value)
            report_field("value", 64'(want.value), 64'(result_bus.value));
          if (result_bus.consumed !== want.consumed)
            report_field("consumed", 64'(want.consumed), 64'(result_bus.consumed));
          if (result_bus.any_digits !== want.any_digits)
            report_field("any_digits", 64'(want.any_digits), 64'(result_bus.any_digits));
        end
      end
      // ready follows a 16-bit mask indexed by stall_tick; the mask is redrawn at random
      stall_tick++;
      if (stall_tick % 128 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'hFFFF;
          1:       stall_mask = 16'($urandom) | 16'h0001;
          2:       stall_mask = 16'($urandom) | 16'($urandom) | 16'($urandom);
          default: stall_mask = (16'($urandom) & 16'($urandom)) | 16'h0001;
        endcase
        if (stall_mask == '0) stall_mask = 16'h0001;
      end
      result_bus.ready <= stall_mask[stall_tick % 16];
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: too long without any transaction on either side
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (chars_bus.valid && chars_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d numbers still awaited",
               $time, QUIET_LIMIT, expected_numbers.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
